// ----- hdl/bmus_pkg.sv -----
// Shared types and constants for the block mean and uniformity score.
`default_nettype none
package bmus_pkg;
  localparam int PIX_W     = 8;
  localparam int NUM_LANES = 3;
  localparam int SCORE_W   = 16;
  localparam int THR_W     = 16;

  // Per-lane commands from the sequencer
  typedef struct packed {
    logic clear;      // start a new block sum
    logic add;        // add the incoming pixel channel
    logic div_start;  // start the mean division
    logic sq_clear;   // clear the deviation accumulator
    logic sq_add;     // add one squared deviation
  } lane_ctrl_t;
endpackage
`default_nettype wire

// ----- hdl/bmus_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmus_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/bmus_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module bmus_div #(
  parameter int N_W = 20,
  parameter int D_W = 13
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [N_W-1:0] dividend_i,
  input  wire logic [D_W-1:0] divisor_i,
  output logic      [N_W-1:0] quot_o,
  output logic                done_o
);
  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] q_q, q_d;
  logic [D_W-1:0] r_q, r_d, dv_q;
  logic [CW-1:0]  cnt_q;
  logic           run_q, done_q;
  logic [D_W:0]   trial;
  logic           ge;

  always_comb begin
    trial = {r_q, q_q[N_W-1]};
    ge    = trial >= {1'b0, dv_q};
    r_d   = ge ? D_W'(trial - {1'b0, dv_q}) : trial[D_W-1:0];
    q_d   = {q_q[N_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CW'(N_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q  <= dividend_i;
      r_q  <= '0;
      dv_q <= divisor_i;
    end else if (run_q) begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign quot_o = q_q;
  assign done_o = done_q;
endmodule
`default_nettype wire

// ----- hdl/bmus_lane.sv -----
// One colour channel: running sum, mean division and squared deviation sum.
`default_nettype none
module bmus_lane #(
  parameter int SUM_W = 20,
  parameter int ACC_W = 29,
  parameter int CNT_W = 13
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire bmus_pkg::lane_ctrl_t    ctrl_i,
  input  wire logic [7:0]              pix_i,
  input  wire logic [CNT_W-1:0]        area_i,
  input  wire logic [7:0]              rd_i,
  output logic      [7:0]              mean_o,
  output logic      [ACC_W-1:0]        acc_o,
  output logic                         done_o
);
  import bmus_pkg::*;

  logic [SUM_W-1:0] sum_q;
  logic [SUM_W-1:0] quot;
  logic [7:0]       mean_q;
  logic [ACC_W-1:0] acc_q;
  logic [7:0]       dev;
  logic [15:0]      sq;
  logic             div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ctrl_i.add) begin
      sum_q <= (ctrl_i.clear ? '0 : sum_q) + SUM_W'(pix_i);
    end else if (ctrl_i.clear) begin
      sum_q <= '0;
    end
  end

  bmus_div #(.N_W(SUM_W), .D_W(CNT_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (area_i),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_comb begin
    dev = (mean_q >= rd_i) ? mean_q - rd_i : rd_i - mean_q;
    sq  = 16'(dev) * 16'(dev);
  end

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      mean_q <= quot[7:0];
    end
    if (ctrl_i.sq_clear) begin
      acc_q <= '0;
    end else if (ctrl_i.sq_add) begin
      acc_q <= acc_q + ACC_W'(sq);
    end
  end

  assign mean_o = mean_q;
  assign acc_o  = acc_q;
  assign done_o = div_done;
endmodule
`default_nettype wire

// ----- hdl/block_mean_and_uniformity_score.sv -----
// Top level: pixel collection, sequencer, three channel lanes and score merge.
// Pixels are taken one per cycle while start is high and busy is low. After
// the last pixel of a block busy stays high while the three mean divisions run
// in parallel lanes, each with a quotient width of 8 + 2*log2(MAX_SIDE) + 1
// bits, then one pass reads the pixel memory one entry a cycle, then a
// bit-serial divider with a quotient 10 bits wider forms the score. The result
// appears for one cycle with valid_o high and cannot be held off; busy is low
// again in that same cycle.
`default_nettype none
module block_mean_and_uniformity_score #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [7:0]  pixel_red_i,
  input  wire logic [7:0]  pixel_green_i,
  input  wire logic [7:0]  pixel_blue_i,
  input  wire logic [6:0]  block_side_i,
  output logic             valid_o,
  output logic [7:0]       mean_red_o,
  output logic [7:0]       mean_green_o,
  output logic [7:0]       mean_blue_o,
  output logic [15:0]      score_o,
  output logic             uniform_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bmus_pkg::*;

  localparam int AREA_MAX = MAX_SIDE * MAX_SIDE;
  localparam int DEPTH    = AREA_MAX > 1 ? AREA_MAX : 2;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int CNT_W    = $clog2(AREA_MAX + 1);
  localparam int SUM_W    = PIX_W + CNT_W;
  localparam int ACC_W    = 16 + CNT_W;
  localparam int TOT_W    = 18 + CNT_W;
  localparam int DV3_W    = CNT_W + 2;

  localparam logic [1:0] REG_SPLIT_THR = 2'd0;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_SQEND  = 3'd4;
  localparam logic [2:0] S_MERGE  = 3'd5;
  localparam logic [2:0] S_SSTART = 3'd6;
  localparam logic [2:0] S_SWAIT  = 3'd7;

  logic [2:0]        state_q;
  logic [CNT_W-1:0]  cnt_q, area_q, idx_q, area_new, cnt_inc;
  logic              rd_vld_q;
  logic [THR_W-1:0]  thr_q;
  logic [TOT_W-1:0]  total_q, squot;
  logic [DV3_W-1:0]  dv3_q;
  logic              sdone;
  logic              acc;
  logic              first;
  logic              last;
  logic [31:0]       side_sat;
  logic [SIDE_W-1:0] side_eff;
  logic [23:0]       rdata;
  lane_ctrl_t        lctrl;
  logic [7:0]        lpix  [NUM_LANES];
  logic [7:0]        lrd   [NUM_LANES];
  logic [7:0]        lmean [NUM_LANES];
  logic [ACC_W-1:0]  lacc  [NUM_LANES];
  logic [NUM_LANES-1:0] ldone;
  logic [15:0]       score_sat;

  assign busy   = state_q != S_IDLE;
  assign acc    = start && !busy;
  assign first  = cnt_q == '0;
  assign pready = 1'b1;
  assign prdata = {16'd0, thr_q};

  always_comb begin
    side_sat = 32'(block_side_i);
    if (side_sat == 32'd0) side_sat = 32'd1;
    if (side_sat > 32'(MAX_SIDE)) side_sat = 32'(MAX_SIDE);
    side_eff = SIDE_W'(side_sat);
    area_new = first ? CNT_W'(side_eff) * CNT_W'(side_eff) : area_q;
    cnt_inc  = cnt_q + 1'b1;
    last     = cnt_inc == area_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && paddr == REG_SPLIT_THR) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  bmus_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (acc),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({pixel_red_i, pixel_green_i, pixel_blue_i}),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    lctrl.clear     = acc && first;
    lctrl.add       = acc;
    lctrl.div_start = state_q == S_MSTART;
    lctrl.sq_clear  = state_q == S_MSTART;
    lctrl.sq_add    = rd_vld_q;
  end

  assign lpix[0] = pixel_red_i;
  assign lpix[1] = pixel_green_i;
  assign lpix[2] = pixel_blue_i;
  assign lrd[0]  = rdata[23:16];
  assign lrd[1]  = rdata[15:8];
  assign lrd[2]  = rdata[7:0];

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bmus_lane #(.SUM_W(SUM_W), .ACC_W(ACC_W), .CNT_W(CNT_W)) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lctrl),
      .pix_i  (lpix[g]),
      .area_i (area_q),
      .rd_i   (lrd[g]),
      .mean_o (lmean[g]),
      .acc_o  (lacc[g]),
      .done_o (ldone[g])
    );
  end

  bmus_div #(.N_W(TOT_W), .D_W(DV3_W)) u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_SSTART),
    .dividend_i (total_q),
    .divisor_i  (dv3_q),
    .quot_o     (squot),
    .done_o     (sdone)
  );

  assign score_sat = (squot > TOT_W'(16'hFFFF)) ? 16'hFFFF : squot[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      area_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      valid_o  <= 1'b0;
    end else begin
      valid_o  <= 1'b0;
      rd_vld_q <= state_q == S_SQ;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            area_q <= area_new;
            if (last) begin
              cnt_q   <= '0;
              state_q <= S_MSTART;
            end else begin
              cnt_q <= cnt_inc;
            end
          end
        end
        S_MSTART: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (ldone[0]) begin
            idx_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == area_q - 1'b1) state_q <= S_SQEND;
        end
        S_SQEND:  state_q <= S_MERGE;
        S_MERGE:  state_q <= S_SSTART;
        S_SSTART: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (sdone) begin
            valid_o <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // merge the lane totals and capture the result
  always_ff @(posedge clk_i) begin
    if (state_q == S_MERGE) begin
      total_q <= TOT_W'(lacc[0]) + TOT_W'(lacc[1]) + TOT_W'(lacc[2]);
      dv3_q   <= DV3_W'({area_q, 1'b0}) + DV3_W'(area_q);
    end
    if (state_q == S_SWAIT && sdone) begin
      mean_red_o   <= lmean[0];
      mean_green_o <= lmean[1];
      mean_blue_o  <= lmean[2];
      score_o      <= score_sat;
      uniform_o    <= score_sat <= thr_q;
    end
  end

`ifndef NO_ASSERTIONS
  a_lanes_together: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ldone == '0) || (ldone == '1))
    else $error("lane dividers out of step");
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while busy");
  a_area_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && cnt_q != '0) |=> $stable(area_q))
    else $error("block area changed within a block");
  a_no_score_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sdone |-> state_q == S_SWAIT)
    else $error("score division finished outside its wait");
`endif
endmodule
`default_nettype wire

// ----- test/bmus_checker.sv -----
// Checker: predicts block means and score from accepted pixels, compares results.
`default_nettype none
module bmus_checker #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [7:0]  pixel_red_i,
  input  wire logic [7:0]  pixel_green_i,
  input  wire logic [7:0]  pixel_blue_i,
  input  wire logic [6:0]  block_side_i,
  input  wire logic        valid_o,
  input  wire logic [7:0]  mean_red_o,
  input  wire logic [7:0]  mean_green_o,
  input  wire logic [7:0]  mean_blue_o,
  input  wire logic [15:0] score_o,
  input  wire logic        uniform_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ADDR_SPLIT_THRESHOLD = 2'd0;

  typedef struct {
    logic [7:0]  mean_r;
    logic [7:0]  mean_g;
    logic [7:0]  mean_b;
    logic [15:0] score;
    logic        uniform;
  } block_verdict_t;

  block_verdict_t verdict_q[$];
  logic [23:0]    pix_mem[MAX_SIDE*MAX_SIDE];
  logic [19:0]    sum_r, sum_g, sum_b;
  int unsigned    pix_cnt;
  int unsigned    side;
  logic [15:0]    threshold;

  assign pending_o = verdict_q.size();

  function automatic longint unsigned sq_diff(int unsigned m, int unsigned v);
    longint unsigned d;
    d = (m >= v) ? m - v : v - m;
    return d * d;
  endfunction

  task automatic take_pixel();
    int unsigned    s, area, mr, mg, mb;
    longint unsigned acc, sc;
    block_verdict_t v;
    if (pix_cnt == 0) begin
      s = block_side_i;
      if (s == 0) s = 1;
      if (s > MAX_SIDE) s = MAX_SIDE;
      side = s;
      sum_r = '0; sum_g = '0; sum_b = '0;
    end
    area = side * side;
    pix_mem[pix_cnt] = {pixel_red_i, pixel_green_i, pixel_blue_i};
    sum_r += pixel_red_i;
    sum_g += pixel_green_i;
    sum_b += pixel_blue_i;
    pix_cnt++;
    if (pix_cnt < area) return;
    mr = sum_r / area;
    mg = sum_g / area;
    mb = sum_b / area;
    acc = 0;
    for (int i = 0; i < area; i++) begin
      acc += sq_diff(mr, pix_mem[i][23:16]);
      acc += sq_diff(mg, pix_mem[i][15:8]);
      acc += sq_diff(mb, pix_mem[i][7:0]);
    end
    sc = acc / (3 * area);
    if (sc > 16'hFFFF) sc = 16'hFFFF;
    v.mean_r  = mr[7:0];
    v.mean_g  = mg[7:0];
    v.mean_b  = mb[7:0];
    v.score   = sc[15:0];
    v.uniform = (sc <= threshold);
    verdict_q.push_back(v);
    pix_cnt = 0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    block_verdict_t v;
    if (!rst_ni) begin
      verdict_q.delete();
      sum_r = '0; sum_g = '0; sum_b = '0;
      pix_cnt = 0;
      side = 0;
      threshold = '0;
      errors_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_SPLIT_THRESHOLD)
        threshold = pwdata[15:0];
      if (valid_o) begin
        if (verdict_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual score %0d", $time, score_o);
          errors_o++;
        end else begin
          v = verdict_q.pop_front();
          check_field("mean_red", v.mean_r, mean_red_o);
          check_field("mean_green", v.mean_g, mean_green_o);
          check_field("mean_blue", v.mean_b, mean_blue_o);
          check_field("score", v.score, score_o);
          check_field("uniform", v.uniform, uniform_o);
        end
      end
      if (start && !busy) take_pixel();
    end
  end
endmodule
`default_nettype wire

// ----- test/tb_block_mean_and_uniformity_score.sv -----
// Testbench top: drives pixel blocks and threshold writes, reports the verdict.
`default_nettype none
module tb_block_mean_and_uniformity_score;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ADDR_SPLIT_THRESHOLD = 2'd0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  pixel_red_i = '0, pixel_green_i = '0, pixel_blue_i = '0;
  logic [6:0]  block_side_i = '0;
  logic        valid_o, uniform_o;
  logic [7:0]  mean_red_o, mean_green_o, mean_blue_o;
  logic [15:0] score_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          errors, pending;
  int          sent;
  bit          allow_gaps;

  block_mean_and_uniformity_score dut (.*);

  bmus_checker chk (.*, .errors_o(errors), .pending_o(pending));

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [6:0] s);
    // random sender gaps
    if (allow_gaps && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start         <= 1'b1;
    pixel_red_i   <= r;
    pixel_green_i <= g;
    pixel_blue_i  <= b;
    block_side_i  <= s;
    do @(posedge clk_i); while (busy);
    sent++;
  endtask

  // One block of random content; side field is random past the first pixel.
  task automatic send_block(logic [6:0] s, int unsigned spread);
    int unsigned eff, base_r, base_g, base_b;
    eff = (s == 0) ? 1 : (s > 64 ? 64 : s);
    base_r = $urandom_range(0, 255);
    base_g = $urandom_range(0, 255);
    base_b = $urandom_range(0, 255);
    for (int i = 0; i < eff * eff; i++)
      send_pixel(8'(base_r + $urandom_range(0, spread)), 8'(base_g + $urandom_range(0, spread)),
                 8'(base_b + $urandom_range(0, spread)),
                 (i == 0) ? s : 7'($urandom_range(0, 127)));
  endtask

  task automatic write_threshold(logic [15:0] value);
    start <= 1'b0;
    // hold until the block has delivered everything
    do @(posedge clk_i); while (pending != 0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_SPLIT_THRESHOLD;
    pwdata  <= {16'($urandom()), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    #30ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sent = 0;
    allow_gaps = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero side, single pixels at the extremes, high-contrast block
    send_pixel(8'hFF, 8'hFF, 8'hFF, 7'd0);
    send_pixel(8'h00, 8'h00, 8'h00, 7'd1);
    send_pixel(8'h00, 8'hFF, 8'h00, 7'd2);
    send_pixel(8'hFF, 8'h00, 8'hFF, 7'd127);
    send_pixel(8'hFF, 8'h00, 8'hFF, 7'd0);
    send_pixel(8'h00, 8'hFF, 8'h00, 7'd5);
    send_pixel(8'h80, 8'h7F, 8'h01, 7'd3);
    for (int i = 0; i < 8; i++)
      send_pixel(8'(i * 31), 8'(255 - i * 29), 8'h55, 7'd0);
    write_threshold(16'hFFFF);
    send_pixel(8'h12, 8'h34, 8'h56, 7'd1);
    send_pixel(8'h00, 8'hFF, 8'h00, 7'd2);
    send_pixel(8'hFF, 8'h00, 8'hFF, 7'd0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 7'd9);
    send_pixel(8'h00, 8'hFF, 8'h00, 7'd64);

    // random: many small blocks
    allow_gaps = 1'b1;
    write_threshold(16'd0);
    while (sent < 1250) begin
      if ($urandom_range(0, 40) == 0) begin
        case ($urandom_range(0, 3))
          0: write_threshold(16'd0);
          1: write_threshold(16'hFFFF);
          default: write_threshold(16'($urandom_range(0, 3000)));
        endcase
      end
      if (sent > 1150) allow_gaps = 1'b0;
      send_block(7'($urandom_range(0, 8)), $urandom_range(0, 1) ? 255 : $urandom_range(0, 40));
    end
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (64) @(posedge clk_i);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire
